@@ sv/nv21_pkg.sv @@
// Shared constants, register indexes and helpers for the NV21 to ARGB converter.
// No dependencies; compile this file first.
`default_nettype none

package nv21_pkg;

  localparam int LUMA_W = 8;
  localparam int CHROMA_W = 8;
  localparam int ARGB_W = 32;

  localparam int CFG_DATA_W = 13;
  localparam int CFG_INDEX_W = 1;
  localparam int ROW_W = 12;
  localparam int ROW_CMP_W = 13;
  localparam int MAX_WIDTH_DEFAULT = 4096;

  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RESET = 13'd640;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RESET = 13'd480;
  localparam logic [ROW_CMP_W-1:0] HEIGHT_LIMIT = 13'd4096;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAME_WIDTH = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_index_t;

  // Fixed-point arithmetic: 10 fractional bits, channels saturate to 18 bits.
  localparam int CHAN_W = 22;
  localparam logic signed [CHAN_W-1:0] CHAN_MAX = 22'sd262143;
  localparam logic signed [11:0] COEF_Y = 12'sd1192;
  localparam logic signed [11:0] COEF_RV = 12'sd1634;
  localparam logic signed [11:0] COEF_GV = 12'sd833;
  localparam logic signed [11:0] COEF_GU = 12'sd400;
  localparam logic signed [12:0] COEF_BU = 13'sd2066;
  localparam logic [LUMA_W-1:0] LUMA_OFFSET = 8'd16;
  localparam logic signed [CHROMA_W:0] CHROMA_OFFSET = 9'sd128;
  localparam logic [7:0] ALPHA = 8'hff;

  // Saturate a channel to 0..262143 and keep its top eight bits.
  function automatic logic [7:0] chan_byte(input logic signed [CHAN_W-1:0] x);
    logic signed [CHAN_W-1:0] s;
    begin
      if (x < 0) begin
        s = '0;
      end else if (x > CHAN_MAX) begin
        s = CHAN_MAX;
      end else begin
        s = x;
      end
      chan_byte = s[17:10];
    end
  endfunction

endpackage

`default_nettype wire

@@ sv/nv21_if.sv @@
// Valid/ready channel interfaces for pixel items in and ARGB items out.
// Depends on nv21_pkg for field widths.
`default_nettype none

interface nv21_in_if;
  import nv21_pkg::*;
  logic valid;
  logic ready;
  logic [LUMA_W-1:0] luma;
  logic [CHROMA_W-1:0] chroma_v;
  logic [CHROMA_W-1:0] chroma_u;

  modport source(output valid, output luma, output chroma_v, output chroma_u, input ready);
  modport sink(input valid, input luma, input chroma_v, input chroma_u, output ready);
endinterface

interface nv21_out_if;
  import nv21_pkg::*;
  logic valid;
  logic ready;
  logic [ARGB_W-1:0] argb;
  logic row_end;
  logic frame_end;

  modport source(output valid, output argb, output row_end, output frame_end, input ready);
  modport sink(input valid, input argb, input row_end, input frame_end, output ready);
endinterface

`default_nettype wire

@@ sv/nv21_pixel_to_argb.sv @@
// NV21 pixel stream to 32-bit ARGB converter, top level.
// Depends on nv21_pkg and the channel interfaces in nv21_if.sv.
//
// Takes one pixel item per clock and returns one ARGB item per clock while the
// output is ready. The first register stage holds the offset luma, the centred
// chroma of the pixel pair and the row and frame end flags; the second stage, the
// output register, holds the packed result after the constant-coefficient products
// and saturation. Both stages move independently, so a stalled output is absorbed
// by the first stage and input continues at full rate whenever the output drains.
// Chroma is sampled on even columns and reused for the odd column that follows.
// frame_width and frame_height must be written through the plain write port while
// the block is idle, which it does not enforce; out-of-range values are clamped when used.
`default_nettype none

module nv21_pixel_to_argb #(
  parameter int MAX_WIDTH = nv21_pkg::MAX_WIDTH_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [nv21_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [nv21_pkg::CFG_DATA_W-1:0]  cfg_data,
  nv21_in_if.sink                               pix_in,
  nv21_out_if.source                            pix_out
);
  import nv21_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int COL_CMP_W = ((COL_W > CFG_DATA_W) ? COL_W : CFG_DATA_W) + 1;
  localparam logic [COL_CMP_W-1:0] WIDTH_MAX = COL_CMP_W'(MAX_WIDTH);
  localparam logic [COL_CMP_W-1:0] WIDTH_MIN = COL_CMP_W'(2);

  logic [CFG_DATA_W-1:0] frame_width;
  logic [CFG_DATA_W-1:0] frame_height;

  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic signed [CHROMA_W:0] held_v;
  logic signed [CHROMA_W:0] held_u;

  // First stage.
  logic s1_valid;
  logic [LUMA_W-1:0] s1_y;
  logic signed [CHROMA_W:0] s1_v;
  logic signed [CHROMA_W:0] s1_u;
  logic s1_row_end;
  logic s1_frame_end;

  // Output stage.
  logic out_valid;
  logic [ARGB_W-1:0] out_argb;
  logic out_row_end;
  logic out_frame_end;

  logic out_load;
  logic s1_load;
  logic in_accept;

  logic [COL_CMP_W-1:0] width_used;
  logic [ROW_CMP_W-1:0] height_used;
  logic [COL_CMP_W-1:0] column_plus;
  logic [ROW_CMP_W-1:0] row_plus;
  logic row_end_now;
  logic frame_end_now;
  logic [LUMA_W-1:0] y_now;
  logic signed [CHROMA_W:0] v_now;
  logic signed [CHROMA_W:0] u_now;

  logic signed [CHAN_W-1:0] y_term;
  logic signed [CHAN_W-1:0] r_sum;
  logic signed [CHAN_W-1:0] g_sum;
  logic signed [CHAN_W-1:0] b_sum;

  assign out_load = !out_valid || pix_out.ready;
  assign s1_load = !s1_valid || out_load;
  assign pix_in.ready = s1_load;
  assign in_accept = pix_in.valid && s1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH: frame_width <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    width_used = COL_CMP_W'(frame_width);
    if (width_used < WIDTH_MIN) begin
      width_used = WIDTH_MIN;
    end else if (width_used > WIDTH_MAX) begin
      width_used = WIDTH_MAX;
    end
    height_used = ROW_CMP_W'(frame_height);
    if (height_used == '0) begin
      height_used = ROW_CMP_W'(1);
    end else if (height_used > HEIGHT_LIMIT) begin
      height_used = HEIGHT_LIMIT;
    end

    column_plus = COL_CMP_W'(column_count) + COL_CMP_W'(1);
    row_plus = ROW_CMP_W'(row_count) + ROW_CMP_W'(1);
    row_end_now = column_plus >= width_used;
    frame_end_now = row_end_now && (row_plus >= height_used);

    y_now = (pix_in.luma > LUMA_OFFSET) ? pix_in.luma - LUMA_OFFSET : '0;
    if (!column_count[0]) begin
      v_now = $signed({1'b0, pix_in.chroma_v}) - CHROMA_OFFSET;
      u_now = $signed({1'b0, pix_in.chroma_u}) - CHROMA_OFFSET;
    end else begin
      v_now = held_v;
      u_now = held_u;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count <= '0;
      held_v <= '0;
      held_u <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= pix_in.valid;
      end
      if (in_accept) begin
        held_v <= v_now;
        held_u <= u_now;
        if (row_end_now) begin
          column_count <= '0;
          row_count <= frame_end_now ? '0 : row_plus[ROW_W-1:0];
        end else begin
          column_count <= column_plus[COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_y <= y_now;
      s1_v <= v_now;
      s1_u <= u_now;
      s1_row_end <= row_end_now;
      s1_frame_end <= frame_end_now;
    end
  end

  always_comb begin
    y_term = CHAN_W'($signed({1'b0, s1_y})) * CHAN_W'(COEF_Y);
    r_sum = y_term + CHAN_W'(s1_v) * CHAN_W'(COEF_RV);
    g_sum = y_term - CHAN_W'(s1_v) * CHAN_W'(COEF_GV) - CHAN_W'(s1_u) * CHAN_W'(COEF_GU);
    b_sum = y_term + CHAN_W'(s1_u) * CHAN_W'(COEF_BU);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      out_argb <= {ALPHA, chan_byte(r_sum), chan_byte(g_sum), chan_byte(b_sum)};
      out_row_end <= s1_row_end;
      out_frame_end <= s1_frame_end;
    end
  end

  assign pix_out.valid = out_valid;
  assign pix_out.argb = out_argb;
  assign pix_out.row_end = out_row_end;
  assign pix_out.frame_end = out_frame_end;

endmodule

`default_nettype wire
